// ===== hdl/lzd_pkg.sv =====
// Shared types and constants for the LZ11/LZ40 stream decompressor.
// No dependencies; the decoder, the top level and the checker import this package.
`timescale 1ns / 1ps
package lzd_pkg;

  localparam int unsigned WINDOW_DEPTH = 4096;
  localparam int unsigned WIN_AW       = $clog2(WINDOW_DEPTH);

  localparam logic [7:0] HDR_LZ11 = 8'h11;
  localparam logic [7:0] HDR_LZ40 = 8'h40;
  localparam logic [7:0] FLAG_MSB = 8'h80;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_HEADER   = 2'd1;
  localparam logic [1:0] ERR_ORDER    = 2'd2;
  localparam logic [1:0] ERR_BACK_REF = 2'd3;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       copy_pending;
    logic       finished;
    logic [1:0] error_code;
  } out_item_t;

endpackage

// ===== hdl/lzd_fifo.sv =====
// Small register queue with occupancy count, used on both sides of the decoder.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module lzd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             wdata_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             rdata_o,
  output logic                         valid_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign count_o = count_q;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/lzd_decoder.sv =====
// Back end: parse state machine, history ring and copy byte resolution.
// Depends on lzd_pkg.
`timescale 1ns / 1ps
module lzd_decoder #(
  parameter int unsigned QDEPTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [23:0]                   cfg_wdata_i,
  input  logic                          item_valid_i,
  input  lzd_pkg::in_item_t             item_i,
  output logic                          item_pop_o,
  input  logic [$clog2(QDEPTH+1)-1:0]   oq_count_i,
  output logic                          res_push_o,
  output lzd_pkg::out_item_t            res_o
);
  import lzd_pkg::*;

  localparam int unsigned CW = $clog2(QDEPTH+1);

  typedef enum logic [3:0] {
    PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_ELEM, PH_TOK1, PH_TOK2, PH_TOK3, PH_COPY
  } phase_e;

  phase_e             phase_q, phase_d;
  logic               lz40_q, lz40_d;
  logic [7:0]         flag_q, flag_d, mask_q, mask_d;
  logic [23:0]        acc_q, acc_d;
  logic [16:0]        rem_q, rem_d;
  logic [12:0]        dist_q, dist_d;
  logic [23:0]        bp_q, bp_d, olen_q;
  logic [WIN_AW-1:0]  wp_q, wp_d;

  logic [7:0]         ring_q [WINDOW_DEPTH];
  logic [7:0]         rd_q;

  logic               s1_valid_q, s1_copy_q, s1_fwd_q;
  logic [7:0]         s1_fwdb_q, s1_byte;
  logic [WIN_AW-1:0]  s1_wa_q;
  out_item_t          s1_item_q, res_d;
  logic               emit, emit_copy;
  logic [7:0]         emit_byte;
  logic [WIN_AW-1:0]  src;
  logic               go, hdr_done, fin;

  // Token decode temporaries
  logic [7:0]  first, t0, t1, t2, t3;
  logic [3:0]  sel;
  logic [2:0]  ntok;
  logic        tok_done;
  logic [16:0] len;
  logic [12:0] tok_dist;
  logic [23:0] room;

  assign go         = item_valid_i &&
                      ((CW+1)'(oq_count_i) + (CW+1)'(s1_valid_q) < (CW+1)'(QDEPTH));
  assign item_pop_o = go;
  assign src        = wp_q - dist_q[WIN_AW-1:0];
  assign hdr_done   = (phase_q != PH_HDR0) && (phase_q != PH_HDR1) &&
                      (phase_q != PH_HDR2) && (phase_q != PH_HDR3);
  assign fin        = hdr_done && (bp_q >= olen_q);

  always_comb begin
    phase_d   = phase_q;
    lz40_d    = lz40_q;
    flag_d    = flag_q;
    mask_d    = mask_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    dist_d    = dist_q;
    bp_d      = bp_q;
    wp_d      = wp_q;
    emit      = 1'b0;
    emit_copy = 1'b0;
    emit_byte = 8'h00;
    res_d     = '0;
    res_d.error_code = ERR_NONE;

    first = 8'h00;
    case (phase_q)
      PH_TOK2: first = acc_q[15:8];
      PH_TOK3: first = acc_q[23:16];
      default: first = acc_q[7:0];
    endcase
    sel  = lz40_q ? first[3:0] : first[7:4];
    ntok = (sel == 4'd0) ? 3'd3 : ((sel == 4'd1) ? 3'd4 : 3'd2);
    case (phase_q)
      PH_TOK1: tok_done = (ntok == 3'd2);
      PH_TOK2: tok_done = (ntok != 3'd4);
      default: tok_done = 1'b1;
    endcase
    t0 = 8'h00; t1 = 8'h00; t2 = 8'h00; t3 = 8'h00;
    case (ntok)
      3'd2:    begin t0 = acc_q[7:0];   t1 = item_i.in_byte; end
      3'd3:    begin t0 = acc_q[15:8];  t1 = acc_q[7:0]; t2 = item_i.in_byte; end
      default: begin
        t0 = acc_q[23:16]; t1 = acc_q[15:8]; t2 = acc_q[7:0]; t3 = item_i.in_byte;
      end
    endcase
    len      = '0;
    tok_dist = '0;
    if (!lz40_q) begin
      case (ntok)
        3'd2: begin
          len      = 17'({4'h0, t0[7:4]}) + 17'd1;
          tok_dist = 13'({t0[3:0], t1}) + 13'd1;
        end
        3'd3: begin
          len      = 17'({t0[3:0], t1[7:4]}) + 17'h11;
          tok_dist = 13'({t1[3:0], t2}) + 13'd1;
        end
        default: begin
          len      = 17'({t0[3:0], t1, t2[7:4]}) + 17'h111;
          tok_dist = 13'({t2[3:0], t3}) + 13'd1;
        end
      endcase
    end else begin
      tok_dist = 13'({t1, t0[7:4]});
      case (ntok)
        3'd2:    len = 17'(t0[3:0]);
        3'd3:    len = 17'(t2) + 17'h10;
        default: len = 17'({t3, t2}) + 17'h110;
      endcase
    end
    room = (olen_q > bp_q) ? (olen_q - bp_q) : '0;

    if (fin) begin
      rem_d   = '0;
      acc_d   = '0;
      phase_d = PH_ELEM;
      if (item_i.command == CMD_ADVANCE) res_d.error_code = ERR_ORDER;
    end else if (item_i.command == CMD_ADVANCE) begin
      if (phase_q == PH_COPY) begin
        emit      = 1'b1;
        emit_copy = 1'b1;
        rem_d     = rem_q - 17'd1;
        if (rem_d == '0) phase_d = PH_ELEM;
      end else begin
        res_d.error_code = ERR_ORDER;
      end
    end else begin
      case (phase_q)
        PH_HDR0: begin
          if (item_i.in_byte == HDR_LZ11 || item_i.in_byte == HDR_LZ40) begin
            lz40_d  = (item_i.in_byte == HDR_LZ40);
            phase_d = PH_HDR1;
          end else begin
            res_d.error_code = ERR_HEADER;
          end
        end
        PH_HDR1: phase_d = PH_HDR2;
        PH_HDR2: phase_d = PH_HDR3;
        PH_HDR3: begin
          phase_d = PH_ELEM;
          mask_d  = '0;
        end
        PH_COPY: res_d.error_code = ERR_ORDER;
        PH_ELEM: begin
          if (mask_q == '0) begin
            flag_d = lz40_q ? (8'h00 - item_i.in_byte) : item_i.in_byte;
            mask_d = FLAG_MSB;
          end else if ((flag_q & mask_q) == '0) begin
            emit      = 1'b1;
            emit_byte = item_i.in_byte;
            mask_d    = mask_q >> 1;
          end else begin
            acc_d   = {16'h0000, item_i.in_byte};
            phase_d = PH_TOK1;
          end
        end
        default: begin
          if (tok_done) begin
            mask_d  = mask_q >> 1;
            phase_d = PH_ELEM;
            acc_d   = '0;
            if (tok_dist == '0 || 24'(tok_dist) > bp_q) begin
              res_d.error_code = ERR_BACK_REF;
            end else begin
              rem_d  = (24'(len) > room) ? room[16:0] : len;
              dist_d = tok_dist;
              if (rem_d != '0) phase_d = PH_COPY;
            end
          end else begin
            acc_d   = {acc_q[15:0], item_i.in_byte};
            phase_d = (phase_q == PH_TOK1) ? PH_TOK2 : PH_TOK3;
          end
        end
      endcase
    end

    if (emit) begin
      wp_d = wp_q + WIN_AW'(1);
      bp_d = bp_q + 24'd1;
    end
    res_d.out_valid    = emit;
    res_d.out_byte     = emit_byte;
    res_d.copy_pending = (phase_d == PH_COPY);
    res_d.finished     = (phase_d != PH_HDR0) && (phase_d != PH_HDR1) &&
                         (phase_d != PH_HDR2) && (phase_d != PH_HDR3) &&
                         (bp_d >= olen_q);
  end

  // Resolve the copied byte: forward the byte written to the ring at the edge of the read if hit.
  assign s1_byte = !s1_copy_q ? s1_item_q.out_byte : (s1_fwd_q ? s1_fwdb_q : rd_q);

  assign res_push_o = s1_valid_q;
  always_comb begin
    res_o          = s1_item_q;
    res_o.out_byte = s1_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR0;
      lz40_q     <= 1'b0;
      flag_q     <= '0;
      mask_q     <= '0;
      acc_q      <= '0;
      rem_q      <= '0;
      dist_q     <= '0;
      bp_q       <= '0;
      wp_q       <= '0;
      olen_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) olen_q <= cfg_wdata_i;
      s1_valid_q <= go;
      if (go) begin
        phase_q <= phase_d;
        lz40_q  <= lz40_d;
        flag_q  <= flag_d;
        mask_q  <= mask_d;
        acc_q   <= acc_d;
        rem_q   <= rem_d;
        dist_q  <= dist_d;
        bp_q    <= bp_d;
        wp_q    <= wp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      s1_item_q <= res_d;
      s1_copy_q <= emit_copy;
      s1_wa_q   <= wp_q;
      s1_fwd_q  <= s1_valid_q && s1_item_q.out_valid && (s1_wa_q == src);
      s1_fwdb_q <= s1_byte;
      rd_q      <= ring_q[src];
    end
    if (s1_valid_q && s1_item_q.out_valid) begin
      ring_q[s1_wa_q] <= s1_byte;
    end
  end

endmodule

// ===== hdl/lz11_lz40_stream_decompressor.sv =====
// Path to the output: input queue, decoder result register, then the result queue.
// Throughput: one item per cycle while the result queue has credit, literal, header,
// token or copy advance alike; the ring is read at decode and written from the result register, with forwarding.
// Reset (rst_ni low, asynchronous) clears queues, parse state and out_length; the
// ring itself is not cleared, and no clearing pass is needed.
`timescale 1ns / 1ps
module lz11_lz40_stream_decompressor #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [23:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lzd_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lzd_pkg::out_item_t  out_item_o
);
  import lzd_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH+1);

  in_item_t        iq_head;
  logic            iq_valid, iq_full, iq_pop;
  logic [CW-1:0]   iq_count, oq_count;
  out_item_t       res;
  logic            res_push, oq_full;

  // Front: hold incoming transfers so the decoder can stall on its own.
  lzd_fifo #(.WIDTH($bits(in_item_t)), .DEPTH(QUEUE_DEPTH)) u_in_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .wdata_i (in_item_i),
    .full_o  (iq_full),
    .pop_i   (iq_pop),
    .rdata_o (iq_head),
    .valid_o (iq_valid),
    .count_o (iq_count)
  );
  assign in_stall_o = iq_full;

  // Back: decode one item a cycle while the result queue has credit.
  lzd_decoder #(.QDEPTH(QUEUE_DEPTH)) u_dec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (iq_valid),
    .item_i       (iq_head),
    .item_pop_o   (iq_pop),
    .oq_count_i   (oq_count),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  // Result queue: credit check in the decoder means a push never meets a full queue.
  lzd_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push && !(oq_full && iq_count == '1)),
    .wdata_i (res),
    .full_o  (oq_full),
    .pop_i   (!out_stall_i),
    .rdata_o (out_item_o),
    .valid_o (out_valid_o),
    .count_o (oq_count)
  );

endmodule

// ===== hdl/lzd_checker.sv =====
// Port-level checks for the decompressor, attached to the top level by bind.
// Depends on lzd_pkg.
`timescale 1ns / 1ps
module lzd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lzd_pkg::out_item_t out_item_o
);
  import lzd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_err_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.error_code != ERR_NONE |-> !out_item_o.out_valid)
    else $error("byte emitted with an error");

  a_copy_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.copy_pending |-> !out_item_o.finished)
    else $error("copy pending after length reached");

  a_hdr_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.error_code == ERR_HEADER |->
      !out_item_o.finished && !out_item_o.copy_pending)
    else $error("header error outside header phase");

endmodule

bind lz11_lz40_stream_decompressor lzd_checker u_lzd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
